@@ design/mpsb_pkg.sv @@
// ----------------------------------------------------------------------------
// mpsb_pkg: shared types and constants for the masked pattern scan
// Request codes, register indexes, default sizes and the command and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package mpsb_pkg;

  localparam int SIG_MAX_DEF       = 32;
  localparam int START_MAX_DEF     = 8;
  localparam int HISTORY_DEPTH_DEF = 512;

  // request codes of an input word
  typedef enum logic [1:0] {
    REQ_LD_SIG   = 2'd0,
    REQ_LD_START = 2'd1,
    REQ_SCAN     = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SIG_LEN   = 2'd0;
  localparam logic [1:0] CFG_START_LEN = 2'd1;
  localparam logic [1:0] CFG_BACK_LIM  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic ld_sig;
    logic ld_start;
    logic scan_wr;
    logic clr_pos;
    logic j_clr;
    logic j_inc;
    logic i_init;
    logic i_inc;
    logic k_clr;
    logic k_inc;
    logic rd_en;
    logic rd_back;
    logic out_load;
    logic res_found;
    logic res_match;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic enough;
    logic sig_ok;
    logic sig_last;
    logic back_zero;
    logic st_ok;
    logic st_last;
    logic back_end;
  } sts_t;

endpackage

@@ design/mpsb_if.sv @@
// ----------------------------------------------------------------------------
// mpsb_if: input and result channels of the masked pattern scan
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mpsb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [4:0] entry_index;
  logic [7:0] byte_value;
  logic [7:0] mask_value;
  logic       last_byte;

  modport source (output valid, req_type, entry_index, byte_value, mask_value,
                  last_byte, input ready);
  modport sink   (input valid, req_type, entry_index, byte_value, mask_value,
                  last_byte, output ready);
endinterface

interface mpsb_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] start_ofs;
  logic [31:0] match_offset;

  modport source (output valid, found, start_ofs, match_offset, input ready);
  modport sink   (input valid, found, start_ofs, match_offset, output ready);
endinterface

@@ design/mpsb_datapath.sv @@
// ----------------------------------------------------------------------------
// mpsb_datapath: tables, history memory, counters and result register
// Executes controller commands; reports compare results as status.
// ----------------------------------------------------------------------------
module mpsb_datapath #(
  parameter int SIG_MAX       = mpsb_pkg::SIG_MAX_DEF,
  parameter int START_MAX     = mpsb_pkg::START_MAX_DEF,
  parameter int HISTORY_DEPTH = mpsb_pkg::HISTORY_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic [4:0]      entry_index,
  input  logic [7:0]      byte_value,
  input  logic [7:0]      mask_value,
  input  mpsb_pkg::cmd_t  cmd,
  output mpsb_pkg::sts_t  sts,
  output logic            found,
  output logic [31:0]     start_ofs,
  output logic [31:0]     match_offset
);

  localparam int SIW = (SIG_MAX > 1) ? $clog2(SIG_MAX) : 1;
  localparam int KW  = (START_MAX > 1) ? $clog2(START_MAX) : 1;
  localparam int AW  = $clog2(HISTORY_DEPTH);

  logic [7:0] sig_mem   [SIG_MAX];
  logic [7:0] mask_mem  [SIG_MAX];
  logic [7:0] start_mem [START_MAX];
  logic [7:0] hist      [HISTORY_DEPTH];

  logic [5:0]     sig_cfg_r;
  logic [3:0]     start_cfg_r;
  logic [7:0]     back_r;
  logic [31:0]    pos_r;
  logic [AW-1:0]  wptr_r;
  logic [SIW-1:0] j_r;
  logic [KW-1:0]  k_r;
  logic [7:0]     i_r;
  logic [7:0]     rdata_r;
  logic           held_r;
  logic           found_r;
  logic [31:0]    soff_r;
  logic [31:0]    moff_r;

  logic [6:0]         slen;
  logic [4:0]         plen;
  logic [31:0]        m;
  logic signed [13:0] rd_dist;
  logic               held;
  logic [AW:0]        wide;
  logic [AW:0]        dd;
  logic [AW:0]        addr;

  // clamped lengths
  always_comb begin
    if (sig_cfg_r == 6'd0) slen = 7'd1;
    else if ({1'b0, sig_cfg_r} > 7'(SIG_MAX)) slen = 7'(SIG_MAX);
    else slen = {1'b0, sig_cfg_r};
    if (start_cfg_r == 4'd0) plen = 5'd1;
    else if ({1'b0, start_cfg_r} > 5'(START_MAX)) plen = 5'(START_MAX);
    else plen = {1'b0, start_cfg_r};
  end

  assign m = pos_r - 32'(slen);

  // distance back from the newest byte, and ring address
  always_comb begin
    if (cmd.rd_back) rd_dist = 14'(slen) + 14'(i_r) - 14'(k_r);
    else rd_dist = 14'(slen) - 14'(j_r);
    held = (rd_dist > 14'sd0) && (rd_dist <= 14'(HISTORY_DEPTH));
    wide = {1'b0, wptr_r};
    dd   = (AW+1)'(rd_dist);
    if (wide >= dd) addr = wide - dd;
    else addr = wide + (AW+1)'(HISTORY_DEPTH) - dd;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_cfg_r   <= 6'd1;
      start_cfg_r <= 4'd1;
      back_r      <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpsb_pkg::CFG_SIG_LEN:   sig_cfg_r   <= cfg_data[5:0];
        mpsb_pkg::CFG_START_LEN: start_cfg_r <= cfg_data[3:0];
        mpsb_pkg::CFG_BACK_LIM:  back_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // tables
  always_ff @(posedge clk) begin
    if (cmd.ld_sig && (32'(entry_index) < 32'(SIG_MAX))) begin
      sig_mem[SIW'(entry_index)]  <= byte_value;
      mask_mem[SIW'(entry_index)] <= mask_value;
    end
    if (cmd.ld_start && (32'(entry_index) < 32'(START_MAX)))
      start_mem[KW'(entry_index)] <= byte_value;
  end

  // history memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.scan_wr) hist[wptr_r] <= byte_value;
    if (cmd.rd_en && held) rdata_r <= hist[AW'(addr)];
  end

  // position and write pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 32'd0;
      wptr_r <= '0;
    end else if (cmd.clr_pos) begin
      pos_r  <= 32'd0;
      wptr_r <= '0;
    end else if (cmd.scan_wr) begin
      pos_r  <= pos_r + 32'd1;
      wptr_r <= (wptr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
  end

  // step counters
  always_ff @(posedge clk) begin
    if (cmd.rd_en) held_r <= held;
    if (cmd.j_clr) j_r <= '0;
    else if (cmd.j_inc) j_r <= j_r + SIW'(1);
    if (cmd.k_clr) k_r <= '0;
    else if (cmd.k_inc) k_r <= k_r + KW'(1);
    if (cmd.i_init) i_r <= 8'd1;
    else if (cmd.i_inc) i_r <= i_r + 8'd1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found_r <= cmd.res_found;
      soff_r  <= cmd.res_found ? (m - 32'(i_r)) : 32'd0;
      moff_r  <= cmd.res_match ? m : 32'd0;
    end
  end

  assign sts.enough    = pos_r >= 32'(slen);
  assign sts.sig_ok    = held_r && ((rdata_r & mask_mem[j_r]) == sig_mem[j_r]);
  assign sts.sig_last  = 7'(j_r) == (slen - 7'd1);
  assign sts.back_zero = (back_r == 8'd0) || (m == 32'd0);
  assign sts.st_ok     = held_r && (rdata_r == start_mem[k_r]);
  assign sts.st_last   = 5'(k_r) == (plen - 5'd1);
  assign sts.back_end  = (i_r == back_r) || (m == 32'(i_r));

  assign found        = found_r;
  assign start_ofs    = soff_r;
  assign match_offset = moff_r;

endmodule

@@ design/mpsb_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpsb_ctrl: sequencer of the masked pattern scan
// Accepts words, steps the signature compare and the backward search,
// and posts one result word per scan.
// ----------------------------------------------------------------------------
module mpsb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     req_type,
  input  logic           last_byte,
  output logic           out_valid,
  input  logic           out_ready,
  input  mpsb_pkg::sts_t sts,
  output mpsb_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_SRD  = 7'b0000100,
    S_SCMP = 7'b0001000,
    S_BRD  = 7'b0010000,
    S_BCMP = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;
  logic   last_r, last_nxt;
  logic   fnd_r, fnd_nxt;
  logic   mat_r, mat_nxt;
  logic   ov_r, ov_nxt;
  logic   acc;
  logic   slot;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;
  assign slot      = !ov_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    last_nxt  = last_r;
    fnd_nxt   = fnd_r;
    mat_nxt   = mat_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.res_found = fnd_r;
    cmd.res_match = mat_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (mpsb_pkg::req_t'(req_type))
            mpsb_pkg::REQ_LD_SIG:   cmd.ld_sig = 1'b1;
            mpsb_pkg::REQ_LD_START: cmd.ld_start = 1'b1;
            mpsb_pkg::REQ_SCAN: begin
              if (!done_r) begin
                cmd.scan_wr = 1'b1;
                last_nxt    = last_byte;
                state_nxt   = S_CHK;
              end else if (last_byte) begin
                cmd.clr_pos = 1'b1;
                done_nxt    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        cmd.j_clr = 1'b1;
        fnd_nxt   = 1'b0;
        mat_nxt   = 1'b0;
        if (sts.enough) state_nxt = S_SRD;
        else if (last_r) state_nxt = S_OUT;
        else state_nxt = S_IDLE;
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (!sts.sig_ok) begin
          if (last_r) state_nxt = S_OUT;
          else state_nxt = S_IDLE;
        end else if (sts.sig_last) begin
          mat_nxt    = 1'b1;
          cmd.i_init = 1'b1;
          cmd.k_clr  = 1'b1;
          if (sts.back_zero) state_nxt = S_OUT;
          else state_nxt = S_BRD;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_BRD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_back = 1'b1;
        state_nxt   = S_BCMP;
      end
      S_BCMP: begin
        if (sts.st_ok && sts.st_last) begin
          fnd_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.st_ok) begin
          cmd.k_inc = 1'b1;
          state_nxt = S_BRD;
        end else if (sts.back_end) begin
          state_nxt = S_OUT;
        end else begin
          cmd.i_inc = 1'b1;
          cmd.k_clr = 1'b1;
          state_nxt = S_BRD;
        end
      end
      S_OUT: begin
        if (slot) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          done_nxt     = mat_r && !last_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // end of image clears the position once the word is finished
    if (last_r && (state_nxt == S_IDLE) && (state_r != S_IDLE)) begin
      cmd.clr_pos = 1'b1;
      done_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      last_r  <= 1'b0;
      fnd_r   <= 1'b0;
      mat_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      last_r  <= last_nxt;
      fnd_r   <= fnd_nxt;
      mat_r   <= mat_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

@@ design/masked_pattern_scan_with_backtrack.sv @@
// ----------------------------------------------------------------------------
// masked_pattern_scan_with_backtrack: masked byte signature scan
// Finds the first masked signature match in an image byte stream and
// searches backward from it for a start pattern.
//
//   channel | dir | payload
//   in_ch   | in  | req_type, entry_index, byte_value, mask_value, last_byte
//   out_ch  | out | found, start_ofs, match_offset
//   cfg_*   | in  | cfg_we, cfg_index, cfg_data
//
// Loads, ignored words and scan bytes after the image result are taken while idle.
// Any other scan byte is written, then checked; each signature byte compared needs
// a history memory read, then a compare, as does each start byte compared during
// the backward search (up to back_limit*start_length compares); a due result is
// posted last. Reset is synchronous; no clearing pass. A result waits in the
// output register; the block stalls only if a second result is due before it goes.
// ----------------------------------------------------------------------------
module masked_pattern_scan_with_backtrack #(
  parameter int SIG_MAX       = mpsb_pkg::SIG_MAX_DEF,
  parameter int START_MAX     = mpsb_pkg::START_MAX_DEF,
  parameter int HISTORY_DEPTH = mpsb_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mpsb_in_if.sink    in_ch,
  mpsb_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  mpsb_pkg::cmd_t cmd;
  mpsb_pkg::sts_t sts;

  mpsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .req_type  (in_ch.req_type),
    .last_byte (in_ch.last_byte),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpsb_datapath #(
    .SIG_MAX       (SIG_MAX),
    .START_MAX     (START_MAX),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .entry_index  (in_ch.entry_index),
    .byte_value   (in_ch.byte_value),
    .mask_value   (in_ch.mask_value),
    .cmd          (cmd),
    .sts          (sts),
    .found        (out_ch.found),
    .start_ofs    (out_ch.start_ofs),
    .match_offset (out_ch.match_offset)
  );

endmodule
